// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros: clocked assertion helpers
// shared wrappers that fix the clock and reset handling of each check
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg: cursor list engine shared definitions
// operation and status codes and the control bundle fed to the cell row
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam logic [3:0] FN_INS_BEFORE = 4'd0;
  localparam logic [3:0] FN_INS_AFTER  = 4'd1;
  localparam logic [3:0] FN_DELETE     = 4'd2;
  localparam logic [3:0] FN_PREV       = 4'd3;
  localparam logic [3:0] FN_NEXT       = 4'd4;
  localparam logic [3:0] FN_FIRST      = 4'd5;
  localparam logic [3:0] FN_LAST       = 4'd6;
  localparam logic [3:0] FN_RD_CUR     = 4'd7;
  localparam logic [3:0] FN_WR_CUR     = 4'd8;
  localparam logic [3:0] FN_RD_IDX     = 4'd9;
  localparam logic [3:0] FN_WR_IDX     = 4'd10;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_BADIDX = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_EDGE   = 3'd4;

  typedef struct packed {
    logic ins;
    logic del;
    logic wr;
  } cle_cell_ctl_t;

endpackage

// ===== rtl/cursor_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// cursor_list_engine_top: ordered word list with a cursor in a row of cells
// insert, delete and write shift or load every cell at once: one beat per cycle
//   unless out_tready stalls; result registered at the edge after the input beat
// reads pass a two-level registered OR readout over the cell row
// one item at a time; the next beat is taken once the read readout is done
// reset (rst_n low, synchronous) empties the list, cursor 0; cell words unset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cursor_list_engine_top
  import cle_pkg::*;
#(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // func[3:0], value[35:4], index[43:36]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // read_data[31:0], status[34:32], count[43:35],
                                  // position[51:44]
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMPW  = (CNT_W > 9) ? CNT_W : 9;
  localparam int GROUP = 16;
  localparam int NGRP  = (CAPACITY + GROUP - 1) / GROUP;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD1  = 2'd1;
  localparam logic [1:0] S_RD2  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] length_r, length_nxt;
  logic [IDX_W-1:0] cursor_r, cursor_nxt;
  logic [IDX_W-1:0] rd_sel_r, rd_sel_nxt;

  logic             out_valid_r;
  logic [31:0]      out_data_r;
  logic [2:0]       out_status_r;
  logic [8:0]       out_count_r;
  logic [7:0]       out_pos_r;

  logic [3:0]            in_func;
  logic [31:0]           in_value;
  logic [7:0]            in_index;
  logic                  accept;
  logic                  is_read;
  logic [2:0]            status;
  logic [DATA_WIDTH-1:0] wdata;
  cle_cell_ctl_t         ctl;
  logic [IDX_W-1:0]      pos;

  logic             len_zero;
  logic             len_full;
  logic             idx_ok;
  logic [CNT_W-1:0] len_dec;
  logic [IDX_W-1:0] cursor_inc;
  logic [CNT_W-1:0] cursor_ext;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd   [NGRP*GROUP];
  logic [DATA_WIDTH-1:0] grp_r     [NGRP];
  logic [DATA_WIDTH-1:0] rd_word;

  assign in_func  = in_tdata[3:0];
  assign in_value = in_tdata[35:4];
  assign in_index = in_tdata[43:36];
  assign wdata    = DATA_WIDTH'(in_value);

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  assign len_zero   = (length_r == '0);
  assign len_full   = (length_r == CNT_W'(CAPACITY));
  assign idx_ok     = (CMPW'(in_index) < CMPW'(length_r));
  assign len_dec    = length_r - CNT_W'(1);
  assign cursor_inc = cursor_r + IDX_W'(1);
  assign cursor_ext = CNT_W'(cursor_r);

  // operation decode
  always_comb begin
    length_nxt = length_r;
    cursor_nxt = cursor_r;
    rd_sel_nxt = rd_sel_r;
    status     = ST_OK;
    is_read    = 1'b0;
    ctl        = '0;
    pos        = cursor_r;
    if (in_func == FN_INS_BEFORE || in_func == FN_INS_AFTER) begin
      if (len_zero) begin
        ctl.wr     = 1'b1;
        pos        = '0;
        length_nxt = CNT_W'(1);
        cursor_nxt = '0;
      end else if (len_full) begin
        status = ST_FULL;
      end else begin
        ctl.ins    = 1'b1;
        length_nxt = length_r + CNT_W'(1);
        if (in_func == FN_INS_BEFORE) begin
          cursor_nxt = cursor_inc;
        end else begin
          pos = cursor_inc;
        end
      end
    end else if (len_zero) begin
      unique case (in_func) inside
        [FN_DELETE:FN_WR_IDX]: status = ST_EMPTY;
        default:               status = ST_OK;
      endcase
    end else begin
      unique case (in_func)
        FN_DELETE: begin
          ctl.del    = 1'b1;
          length_nxt = len_dec;
          if (len_dec == '0) begin
            cursor_nxt = '0;
          end else if (cursor_ext == len_dec) begin
            cursor_nxt = cursor_r - IDX_W'(1);
          end
        end
        FN_PREV: begin
          if (cursor_r == '0) begin
            status = ST_EDGE;
          end else begin
            cursor_nxt = cursor_r - IDX_W'(1);
          end
        end
        FN_NEXT: begin
          if (cursor_ext + CNT_W'(1) >= length_r) begin
            status = ST_EDGE;
          end else begin
            cursor_nxt = cursor_inc;
          end
        end
        FN_FIRST:  cursor_nxt = '0;
        FN_LAST:   cursor_nxt = IDX_W'(len_dec);
        FN_RD_CUR: begin
          is_read    = 1'b1;
          rd_sel_nxt = cursor_r;
        end
        FN_WR_CUR: ctl.wr = 1'b1;
        FN_RD_IDX: begin
          if (!idx_ok) begin
            status = ST_BADIDX;
          end else begin
            is_read    = 1'b1;
            rd_sel_nxt = IDX_W'(in_index);
          end
        end
        FN_WR_IDX: begin
          if (!idx_ok) begin
            status = ST_BADIDX;
          end else begin
            ctl.wr = 1'b1;
            pos    = IDX_W'(in_index);
          end
        end
        default: status = ST_OK;
      endcase
    end
    if (!accept) begin
      ctl        = '0;
      length_nxt = length_r;
      cursor_nxt = cursor_r;
      rd_sel_nxt = rd_sel_r;
    end
  end

  // cell row
  for (genvar k = 0; k < NGRP*GROUP; k++) begin : g_cell
    if (k < CAPACITY) begin : g_real
      cle_cell #(
        .IDX_W      (IDX_W),
        .DATA_WIDTH (DATA_WIDTH),
        .CELL_IDX   (k)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .pos        (pos),
        .wdata      (wdata),
        .left_data  ((k == 0) ? '0 : cell_data[(k == 0) ? 0 : k-1]),
        .right_data (cell_data[(k == CAPACITY-1) ? k : k+1]),
        .rd_sel     (rd_sel_r),
        .data_o     (cell_data[k]),
        .rd_o       (cell_rd[k])
      );
    end else begin : g_pad
      assign cell_rd[k] = '0;
    end
  end

  // readout: OR per group of cells, then across groups
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    logic [DATA_WIDTH-1:0] grp_or;
    always_comb begin
      grp_or = '0;
      for (int j = 0; j < GROUP; j++) begin
        grp_or = grp_or | cell_rd[g*GROUP + j];
      end
    end
    always_ff @(posedge clk) begin
      grp_r[g] <= grp_or;
    end
  end

  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_word = rd_word | grp_r[g];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && is_read) state_nxt = S_RD1;
      S_RD1:   state_nxt = S_RD2;
      S_RD2:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      length_r    <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      length_r <= length_nxt;
      cursor_r <= cursor_nxt;
      if (accept) begin
        out_valid_r <= !is_read;
      end else if (state_r == S_RD2) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_sel_r <= rd_sel_nxt;
    if (accept) begin
      out_data_r   <= '0;
      out_status_r <= status;
      out_count_r  <= 9'(length_nxt);
      out_pos_r    <= 8'(cursor_nxt);
    end else if (state_r == S_RD2) begin
      out_data_r <= 32'(rd_word);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_pos_r, out_count_r, out_status_r, out_data_r};

  `ASSERT_CLK(a_len_cap, length_r <= CNT_W'(CAPACITY), "length above capacity")
  `ASSERT_CLK(a_cur_in_list, (length_r == '0) || (cursor_ext < length_r), "cursor out of list")
  `ASSERT_CLK(a_empty_cur, (length_r != '0) || (cursor_r == '0), "cursor set on empty list")
  `ASSERT_CLK(a_rd_done, (state_r == S_RD2) |=> out_valid_r, "read result not presented")
  `ASSERT_ALWAYS(a_rst, !rst_n |=> (length_r == '0) && !out_valid_r, "reset did not clear")

endmodule

// ===== rtl/cle_cell.sv =====
// ----------------------------------------------------------------------------
// cle_cell: one list entry
// holds a word; on insert, a cell above the operation position takes its left
// neighbor; on delete, a cell at or above it takes its right neighbor; on insert
// or write, the cell at the operation position takes the new word
module cle_cell
  import cle_pkg::*;
#(
  parameter int IDX_W      = 8,
  parameter int DATA_WIDTH = 32,
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk,
  input  cle_cell_ctl_t         ctl,
  input  logic [IDX_W-1:0]      pos,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [IDX_W-1:0]      rd_sel,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] rd_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  at;
  logic                  above;

  assign at    = (pos == MY_IDX);
  assign above = (pos < MY_IDX);

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins && at) begin
      data_nxt = wdata;
    end else if (ctl.ins && above) begin
      data_nxt = left_data;
    end else if (ctl.del && (at || above)) begin
      data_nxt = right_data;
    end else if (ctl.wr && at) begin
      data_nxt = wdata;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign rd_o   = (rd_sel == MY_IDX) ? data_r : '0;

endmodule

// ===== dv/cursor_list_engine_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_list_engine_top_test: self-checking bench for the cursor list engine
// a directed table covers the empty list, boundary moves, bad indexes and
// no-op codes; random traffic then fills the store to full, drains it and
// mixes all operations, checked beat by beat against a behavioral list
// model. both stream sides idle at random, with one long output hold-off
// ----------------------------------------------------------------------------
module cursor_list_engine_top_test;
  import cle_pkg::*;

  localparam int LIST_DEPTH     = 256;
  localparam int RANDOM_BEATS   = 1850;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int LONG_HOLD      = 300;
  localparam int LONG_HOLD_AT   = 200;

  localparam logic [3:0] FN_NOP_LO = 4'd11;
  localparam logic [3:0] FN_NOP_HI = 4'd15;

  typedef struct packed {
    logic [7:0]  index;
    logic [31:0] value;
    logic [3:0]  func;
  } list_beat_t;

  typedef struct packed {
    logic [7:0]  position;
    logic [8:0]  count;
    logic [2:0]  status;
    logic [31:0] read_data;
  } list_result_t;

  typedef struct {
    list_beat_t   beat;
    bit           pinned;
    list_result_t want;
  } directed_row_t;

  typedef struct {
    bit           pinned;
    list_result_t want;
  } pinned_result_t;

  typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIX} fill_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;

  // list model state
  logic [31:0] list_words [LIST_DEPTH];
  int          list_len;
  int          list_cursor;

  list_result_t   pending_results [$];
  pinned_result_t pinned_q [$];
  directed_row_t  directed_ops [$];

  int fail_count;
  int beats_in;
  int idle_cycles;
  int burst_left;

  cursor_list_engine_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic list_result_t apply_list_op(list_beat_t b);
    list_result_t r;
    int k;
    r = '0;
    r.status = ST_OK;
    if (b.func == FN_INS_BEFORE || b.func == FN_INS_AFTER) begin
      if (list_len == 0) begin
        list_words[0] = b.value;
        list_cursor = 0;
        list_len = 1;
      end else if (list_len >= LIST_DEPTH) begin
        r.status = ST_FULL;
      end else if (b.func == FN_INS_BEFORE) begin
        for (k = list_len; k > list_cursor; k--) list_words[k] = list_words[k-1];
        list_words[list_cursor] = b.value;
        list_cursor++;
        list_len++;
      end else begin
        for (k = list_len; k > list_cursor + 1; k--) list_words[k] = list_words[k-1];
        list_words[list_cursor+1] = b.value;
        list_len++;
      end
    end else if (b.func <= FN_WR_IDX) begin
      if (list_len == 0) begin
        r.status = ST_EMPTY;
      end else begin
        case (b.func)
          FN_DELETE: begin
            for (k = list_cursor; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
            list_len--;
            if (list_len == 0) list_cursor = 0;
            else if (list_cursor == list_len) list_cursor--;
          end
          FN_PREV: begin
            if (list_cursor == 0) r.status = ST_EDGE;
            else list_cursor--;
          end
          FN_NEXT: begin
            if (list_cursor + 1 >= list_len) r.status = ST_EDGE;
            else list_cursor++;
          end
          FN_FIRST:  list_cursor = 0;
          FN_LAST:   list_cursor = list_len - 1;
          FN_RD_CUR: r.read_data = list_words[list_cursor];
          FN_WR_CUR: list_words[list_cursor] = b.value;
          default: begin
            if (int'(b.index) >= list_len) r.status = ST_BADIDX;
            else if (b.func == FN_RD_IDX) r.read_data = list_words[b.index];
            else list_words[b.index] = b.value;
          end
        endcase
      end
    end
    r.count    = list_len[8:0];
    r.position = list_cursor[7:0];
    return r;
  endfunction

  function automatic directed_row_t make_row(logic [3:0] func, logic [31:0] value,
                                             logic [7:0] index, bit pinned,
                                             logic [31:0] rd, logic [2:0] st,
                                             logic [8:0] cnt, logic [7:0] pos);
    directed_row_t row;
    row.beat   = '{index: index, value: value, func: func};
    row.pinned = pinned;
    row.want   = '{position: pos, count: cnt, status: st, read_data: rd};
    return row;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // sender pacing: bursts of random length, random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // call right after a falling edge
  task automatic send_beat(list_beat_t b, bit pinned, list_result_t want);
    pinned_q.push_back(pinned_result_t'{pinned: pinned, want: want});
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, b};
    do @(posedge clk); while (!in_tready);
  endtask

  // monitors, model update and watchdog
  always @(posedge clk) begin : monitor
    list_beat_t     b;
    list_result_t   pred;
    list_result_t   want;
    list_result_t   got;
    pinned_result_t pin;
    bit             moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        got = out_tdata[51:0];
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: %0h", out_tdata);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("status", want.status, got.status);
          check_field("count", want.count, got.count);
          check_field("position", want.position, got.position);
        end
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        b = in_tdata[43:0];
        pred = apply_list_op(b);
        pin = pinned_q.pop_front();
        pending_results.push_back(pin.pinned ? pin.want : pred);
        beats_in++;
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("cursor_list_engine_top_test failed");
        $finish;
      end
    end
  end

  // receiver: random stall phases plus one long hold-off to back up the input
  initial begin : receiver
    int phase_left;
    int phase_mode;
    int hold_left;
    bit long_done;
    phase_left = 0;
    phase_mode = 0;
    hold_left  = 0;
    long_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!long_done && beats_in >= LONG_HOLD_AT) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_mode = $urandom_range(0, 3);
          phase_left = $urandom_range(20, 200);
        end
        phase_left--;
        case (phase_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= phase_left[2];
        endcase
      end
    end
  end

  initial begin : stimulus
    list_beat_t   b;
    fill_mode_t   mode;
    int           full_beats;
    int           mix_left;
    int           pick;
    int           n;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    list_len    = 0;
    list_cursor = 0;
    fail_count  = 0;
    beats_in    = 0;
    idle_cycles = 0;
    burst_left  = 0;

    // empty list
    directed_ops.push_back(make_row(FN_DELETE, 32'h0, 8'h0, 1, 32'h0, ST_EMPTY, 0, 0));
    directed_ops.push_back(make_row(FN_PREV, 32'h0, 8'h0, 1, 32'h0, ST_EMPTY, 0, 0));
    directed_ops.push_back(make_row(FN_NEXT, 32'h0, 8'h0, 1, 32'h0, ST_EMPTY, 0, 0));
    directed_ops.push_back(make_row(FN_FIRST, 32'h0, 8'h0, 1, 32'h0, ST_EMPTY, 0, 0));
    directed_ops.push_back(make_row(FN_LAST, 32'h0, 8'h0, 1, 32'h0, ST_EMPTY, 0, 0));
    directed_ops.push_back(make_row(FN_RD_CUR, 32'h0, 8'h0, 1, 32'h0, ST_EMPTY, 0, 0));
    directed_ops.push_back(make_row(FN_WR_CUR, 32'hdeadbeef, 8'h0, 1, 32'h0, ST_EMPTY, 0, 0));
    directed_ops.push_back(make_row(FN_RD_IDX, 32'h0, 8'h0, 1, 32'h0, ST_EMPTY, 0, 0));
    directed_ops.push_back(make_row(FN_WR_IDX, 32'hffffffff, 8'hff, 1, 32'h0, ST_EMPTY, 0, 0));
    directed_ops.push_back(make_row(FN_NOP_HI, 32'hffffffff, 8'hff, 1, 32'h0, ST_OK, 0, 0));
    // single entry
    directed_ops.push_back(make_row(FN_INS_AFTER, 32'hffffffff, 8'h0, 1, 32'h0, ST_OK, 1, 0));
    directed_ops.push_back(make_row(FN_RD_CUR, 32'h0, 8'h0, 1, 32'hffffffff, ST_OK, 1, 0));
    directed_ops.push_back(make_row(FN_PREV, 32'h0, 8'h0, 1, 32'h0, ST_EDGE, 1, 0));
    directed_ops.push_back(make_row(FN_NEXT, 32'h0, 8'h0, 1, 32'h0, ST_EDGE, 1, 0));
    // insert before keeps the cursor on its entry
    directed_ops.push_back(make_row(FN_INS_BEFORE, 32'h0, 8'h0, 1, 32'h0, ST_OK, 2, 1));
    directed_ops.push_back(make_row(FN_INS_AFTER, 32'ha5a5a5a5, 8'h0, 0, 32'h0, ST_OK, 0, 0));
    directed_ops.push_back(make_row(FN_RD_IDX, 32'h0, 8'hff, 1, 32'h0, ST_BADIDX, 3, 1));
    directed_ops.push_back(make_row(FN_RD_IDX, 32'h0, 8'h3, 1, 32'h0, ST_BADIDX, 3, 1));
    directed_ops.push_back(make_row(FN_RD_IDX, 32'h0, 8'h0, 0, 32'h0, ST_OK, 0, 0));
    directed_ops.push_back(make_row(FN_WR_IDX, 32'h12345678, 8'h2, 0, 32'h0, ST_OK, 0, 0));
    directed_ops.push_back(make_row(FN_LAST, 32'h0, 8'h0, 0, 32'h0, ST_OK, 0, 0));
    directed_ops.push_back(make_row(FN_NEXT, 32'h0, 8'h0, 0, 32'h0, ST_OK, 0, 0));
    // delete at the last entry steps the cursor back
    directed_ops.push_back(make_row(FN_DELETE, 32'h0, 8'h0, 0, 32'h0, ST_OK, 0, 0));
    directed_ops.push_back(make_row(FN_FIRST, 32'h0, 8'h0, 0, 32'h0, ST_OK, 0, 0));
    directed_ops.push_back(make_row(FN_WR_CUR, 32'h80000001, 8'h0, 0, 32'h0, ST_OK, 0, 0));
    directed_ops.push_back(make_row(FN_RD_CUR, 32'h0, 8'h0, 0, 32'h0, ST_OK, 0, 0));
    directed_ops.push_back(make_row(FN_NOP_LO, 32'h5a5a5a5a, 8'h55, 0, 32'h0, ST_OK, 0, 0));
    directed_ops.push_back(make_row(FN_DELETE, 32'h0, 8'h0, 0, 32'h0, ST_OK, 0, 0));
    // deleting the only entry leaves the cursor at 0
    directed_ops.push_back(make_row(FN_DELETE, 32'h0, 8'h0, 1, 32'h0, ST_OK, 0, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_ops[i]) begin
      pace_sender();
      @(negedge clk);
      send_beat(directed_ops[i].beat, directed_ops[i].pinned, directed_ops[i].want);
    end

    mode       = MODE_GROW;
    full_beats = $urandom_range(10, 30);
    mix_left   = 0;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      pace_sender();
      @(negedge clk);
      case (mode)
        MODE_GROW: begin
          if (list_len >= LIST_DEPTH) begin
            if (full_beats == 0) mode = MODE_SHRINK;
            else full_beats--;
          end
        end
        MODE_SHRINK: begin
          if (list_len == 0) begin
            mode = MODE_MIX;
            mix_left = $urandom_range(40, 120);
          end
        end
        default: begin
          if (mix_left == 0) begin
            mode = MODE_GROW;
            full_beats = $urandom_range(10, 30);
          end else begin
            mix_left--;
          end
        end
      endcase

      pick = $urandom_range(0, 99);
      if (mode == MODE_GROW && pick < 80)
        b.func = $urandom_range(0, 1) ? FN_INS_AFTER : FN_INS_BEFORE;
      else if (mode == MODE_SHRINK && pick < 75)
        b.func = FN_DELETE;
      else if (mode == MODE_MIX)
        b.func = $urandom_range(0, 15);
      else
        b.func = $urandom_range(2, 15);

      pick = $urandom_range(0, 9);
      if (pick == 0) b.value = 32'h0;
      else if (pick == 1) b.value = 32'hffffffff;
      else b.value = $urandom;

      if (list_len > 0 && $urandom_range(0, 9) < 7)
        b.index = $urandom_range(0, list_len - 1);
      else
        b.index = $urandom_range(0, 255);

      send_beat(b, 1'b0, '0);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("cursor_list_engine_top_test passed");
    end else begin
      $display("cursor_list_engine_top_test failed");
    end
    $finish;
  end

endmodule
